### rtl/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types and constants for the ranked tree SPR move unit.
// ----------------------------------------------------------------------------
package rts_pkg;

    localparam int IDX_W      = 7;
    localparam int LEAVES_DEF = 64;

    localparam logic [IDX_W-1:0] NONE_IDX = 7'd127;

    // Request codes
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_MOVE = 2'd2;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] parent;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } t_entry;

    // Per-field write enables of the node memory
    typedef struct packed {
        logic parent;
        logic left;
        logic right;
    } t_wmask;

    localparam t_entry NONE_ENTRY = '{parent: NONE_IDX, left: NONE_IDX, right: NONE_IDX};

endpackage

### rtl/rts_if.sv
// ----------------------------------------------------------------------------
// rts_req_if / rts_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface rts_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [rts_pkg::IDX_W-1:0] node_index;
    logic [rts_pkg::IDX_W-1:0] load_parent;
    logic [rts_pkg::IDX_W-1:0] load_left;
    logic [rts_pkg::IDX_W-1:0] load_right;
    logic [rts_pkg::IDX_W-1:0] sibling_index;
    logic                      moving_child;

    modport source (
        output valid, req_type, node_index, load_parent, load_left, load_right,
               sibling_index, moving_child,
        input  ready
    );
    modport sink (
        input  valid, req_type, node_index, load_parent, load_left, load_right,
               sibling_index, moving_child,
        output ready
    );
endinterface

interface rts_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [rts_pkg::IDX_W-1:0] read_parent;
    logic [rts_pkg::IDX_W-1:0] read_left;
    logic [rts_pkg::IDX_W-1:0] read_right;

    modport source (
        output valid, status, read_parent, read_left, read_right,
        input  ready
    );
    modport sink (
        input  valid, status, read_parent, read_left, read_right,
        output ready
    );
endinterface

### rtl/ranked_tree_spr_move_unit.sv
// ----------------------------------------------------------------------------
// ranked_tree_spr_move_unit
// Node table of a ranked binary tree with load, read and ranked SPR move.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request item: load a node entry, read it back, or
//   apply an SPR move of rank node_index above sibling_index. o_rsp returns
//   one result item per request, in request order.
//   The table sits in one single-port node memory (parent, left, right per
//   entry, per-field write enables, registered read). A sequencer does all
//   reads and writes of a request in order, one access per cycle. The next
//   item is accepted the cycle after the result moves into the output
//   register, so no new item is taken while one is in progress. A move
//   is bounded by the ten ordered accesses to the single memory port; a
//   rejected move ends early.
//   A result waits in the output register while o_rsp.ready is low; one more
//   item is taken and finished, then its result holds until the register
//   frees up.
//   Reset clears the sequencer and the output valid only; table entries are
//   undefined until loaded.
// ----------------------------------------------------------------------------
module ranked_tree_spr_move_unit #(
    parameter int LEAVES = rts_pkg::LEAVES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rts_req_if.sink       i_req,
    rts_rsp_if.source     o_rsp
);

    localparam int NODE_COUNT = 2 * LEAVES - 1;
    localparam int DEPTH      = (NODE_COUNT < 127) ? NODE_COUNT : 127;
    localparam int AW         = $clog2(DEPTH);
    localparam int IW         = rts_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RDATA, S_SIB, S_R, S_OP, S_W2, S_RDNP, S_NP,
        S_W4, S_W5, S_W6, S_DONE
    } t_state;

    t_state r_state;

    // request context
    logic [IW-1:0] r_r, r_sib, r_new_par, r_old_par, r_old_sib;
    logic          r_mc;
    logic [1:0]    r_mask;

    // staged result and output register
    logic          r_st;
    logic [IW-1:0] r_rp, r_rl, r_rr;
    logic          r_ov, r_ost;
    logic [IW-1:0] r_orp, r_orl, r_orr;

    // node memory
    rts_pkg::t_entry mem [DEPTH];
    rts_pkg::t_entry r_rd_data;
    logic            r_rd_ok;

    rts_pkg::t_wmask mem_we;
    logic [IW-1:0]   mem_wa, mem_ra;
    rts_pkg::t_entry mem_wd;
    logic            mem_re;
    logic            wa_ok, ra_ok;

    rts_pkg::t_entry view;
    logic [IW-1:0]   cmp_idx;
    logic [1:0]      match;
    logic            accept;
    logic            sib_above;
    logic            ps_below;

    assign accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // out-of-table entries read as "none"
    assign view     = r_rd_ok ? r_rd_data : rts_pkg::NONE_ENTRY;
    assign cmp_idx  = (r_state == S_OP) ? r_r : r_sib;
    assign match    = {view.right == cmp_idx, view.left == cmp_idx};
    assign sib_above = i_req.sibling_index > i_req.node_index;
    assign ps_below  = view.parent < r_r;

    assign wa_ok = mem_wa < IW'(DEPTH);
    assign ra_ok = mem_ra < IW'(DEPTH);

    always_comb begin
        mem_we = '0;
        mem_wa = r_r;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = r_r;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.req_type)
                        rts_pkg::REQ_LOAD: begin
                            mem_we = '{parent: 1'b1, left: 1'b1, right: 1'b1};
                            mem_wa = i_req.node_index;
                            mem_wd = '{parent: i_req.load_parent, left: i_req.load_left,
                                       right: i_req.load_right};
                        end
                        rts_pkg::REQ_READ: begin
                            mem_re = 1'b1;
                            mem_ra = i_req.node_index;
                        end
                        rts_pkg::REQ_MOVE: begin
                            mem_re = !sib_above;
                            mem_ra = i_req.sibling_index;
                        end
                        default: ;
                    endcase
                end
            end
            S_SIB: begin
                mem_re = !ps_below;
                mem_ra = r_r;
            end
            S_R: begin
                mem_re = 1'b1;
                mem_ra = view.parent;
            end
            S_OP: begin
                // kept child goes up to the old parent
                mem_we.parent = |match;
                mem_wa        = r_old_sib;
                mem_wd.parent = r_old_par;
            end
            S_W2: begin
                mem_we.left  = r_mask[0];
                mem_we.right = r_mask[1];
                mem_wa       = r_old_par;
                mem_wd.left  = r_old_sib;
                mem_wd.right = r_old_sib;
            end
            S_RDNP: begin
                mem_re = 1'b1;
                mem_ra = r_new_par;
            end
            S_NP: begin
                mem_we.parent = |match;
                mem_wa        = r_r;
                mem_wd.parent = r_new_par;
            end
            S_W4: begin
                mem_we.left  = r_mask[0];
                mem_we.right = r_mask[1];
                mem_wa       = r_new_par;
                mem_wd.left  = r_r;
                mem_wd.right = r_r;
            end
            S_W5: begin
                mem_we.parent = 1'b1;
                mem_wa        = r_sib;
                mem_wd.parent = r_r;
            end
            S_W6: begin
                // the staying child slot takes the new sibling
                mem_we.left  = r_mc;
                mem_we.right = !r_mc;
                mem_wa       = r_r;
                mem_wd.left  = r_sib;
                mem_wd.right = r_sib;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wa_ok) begin
            if (mem_we.parent) begin
                mem[mem_wa[AW-1:0]].parent <= mem_wd.parent;
            end
            if (mem_we.left) begin
                mem[mem_wa[AW-1:0]].left <= mem_wd.left;
            end
            if (mem_we.right) begin
                mem[mem_wa[AW-1:0]].right <= mem_wd.right;
            end
        end
        if (mem_re) begin
            r_rd_ok <= ra_ok;
            if (ra_ok) begin
                r_rd_data <= mem[mem_ra[AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // load a finished item, else drop the delivered one
            if (r_state == S_DONE && (!r_ov || o_rsp.ready)) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_r   <= i_req.node_index;
                        r_sib <= i_req.sibling_index;
                        r_mc  <= i_req.moving_child;
                        r_st  <= rts_pkg::STATUS_OK;
                        r_rp  <= '0;
                        r_rl  <= '0;
                        r_rr  <= '0;
                        unique case (i_req.req_type)
                            rts_pkg::REQ_READ: r_state <= S_RDATA;
                            rts_pkg::REQ_MOVE: begin
                                if (sib_above) begin
                                    r_st    <= rts_pkg::STATUS_REJECT;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_SIB;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RDATA: begin
                    r_rp    <= view.parent;
                    r_rl    <= view.left;
                    r_rr    <= view.right;
                    r_state <= S_DONE;
                end
                S_SIB: begin
                    r_new_par <= view.parent;
                    if (ps_below) begin
                        r_st    <= rts_pkg::STATUS_REJECT;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_R;
                    end
                end
                S_R: begin
                    r_old_par <= view.parent;
                    r_old_sib <= r_mc ? view.left : view.right;
                    r_state   <= S_OP;
                end
                S_OP: begin
                    r_mask  <= match;
                    r_state <= S_W2;
                end
                S_W2:   r_state <= S_RDNP;
                S_RDNP: r_state <= S_NP;
                S_NP: begin
                    r_mask  <= match;
                    r_state <= S_W4;
                end
                S_W4: r_state <= S_W5;
                S_W5: r_state <= S_W6;
                S_W6: r_state <= S_DONE;
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ov || o_rsp.ready) begin
                        r_ost   <= r_st;
                        r_orp   <= r_rp;
                        r_orl   <= r_rl;
                        r_orr   <= r_rr;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_ost;
    assign o_rsp.read_parent = r_orp;
    assign o_rsp.read_left   = r_orl;
    assign o_rsp.read_right  = r_orr;

endmodule

### rtl/rts_checker.sv
// ----------------------------------------------------------------------------
// rts_checker
// Port-level checks on the ranked tree SPR move unit.
// ----------------------------------------------------------------------------
module rts_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_req_valid,
    input logic                      i_req_ready,
    input logic                      o_rsp_valid,
    input logic                      o_rsp_ready,
    input logic                      o_rsp_status,
    input logic [rts_pkg::IDX_W-1:0] o_rsp_read_parent,
    input logic [rts_pkg::IDX_W-1:0] o_rsp_read_left,
    input logic [rts_pkg::IDX_W-1:0] o_rsp_read_right
);

    logic       in_acc, out_acc;
    logic [1:0] r_cnt;

    assign in_acc  = i_req_valid && i_req_ready;
    assign out_acc = o_rsp_valid && o_rsp_ready;

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc && r_cnt != 2'd3) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (!in_acc && out_acc && r_cnt != 2'd0) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> r_cnt != 2'd0)
        else $error("result shown with no item outstanding");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("more than two items outstanding");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp_status) |->
            (o_rsp_read_parent == '0 && o_rsp_read_left == '0 && o_rsp_read_right == '0))
        else $error("rejected move carries read data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp_ready) |=>
            (o_rsp_valid && $stable(o_rsp_status) && $stable(o_rsp_read_parent)))
        else $error("stalled result changed");

endmodule

bind ranked_tree_spr_move_unit rts_checker u_rts_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .o_rsp_valid       (o_rsp.valid),
    .o_rsp_ready       (o_rsp.ready),
    .o_rsp_status      (o_rsp.status),
    .o_rsp_read_parent (o_rsp.read_parent),
    .o_rsp_read_left   (o_rsp.read_left),
    .o_rsp_read_right  (o_rsp.read_right)
);
